[hdl/fsfla_pkg.sv]
// Shared constants, status codes and controller/datapath types for the slot allocator.
`default_nettype none
package fsfla_pkg;

    localparam int SLOT_BYTES  = 16;
    localparam int BATCH_SLOTS = 128;
    localparam int NUM_CHUNKS  = 8;

    localparam int SLOT_W     = 10;
    localparam int SLOT_SPACE = 1 << SLOT_W;
    localparam int LINK_W     = SLOT_W + 1;
    localparam int SIZE_W     = 16;
    localparam int STATUS_W   = 3;

    // chunks that actually fit in the slot space
    localparam int FIT_CHUNKS = SLOT_SPACE / BATCH_SLOTS;
    localparam int MAX_CHUNKS = (NUM_CHUNKS < FIT_CHUNKS) ? NUM_CHUNKS : FIT_CHUNKS;
    localparam int CHUNK_W    = $clog2(NUM_CHUNKS + 1);
    localparam int BASE_W     = CHUNK_W + SLOT_W + 1;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd4;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic                push;
        logic                pop_rd;
        logic                pop_wb;
        logic                carve_start;
        logic                carve_step;
        logic                post;
        logic [STATUS_W-1:0] post_status;
    } t_dp_cmd;

    typedef struct packed {
        logic head_valid;
        logic can_carve;
        logic oversize;
        logic carve_last;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

[hdl/fsfla_dp.sv]
// Datapath: link memory, free-list head, chunk carving and the result register.
`default_nettype none
module fsfla_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire fsfla_pkg::t_dp_cmd      i_cmd,
    output fsfla_pkg::t_dp_sts           o_sts,
    input  wire [fsfla_pkg::SIZE_W-1:0]  i_request_size,
    input  wire [fsfla_pkg::SLOT_W-1:0]  i_slot_index,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [fsfla_pkg::SLOT_W-1:0] o_granted_slot,
    output logic [fsfla_pkg::STATUS_W-1:0] o_status
);
    import fsfla_pkg::*;

    logic [LINK_W-1:0]  r_link_mem [SLOT_SPACE];
    logic [LINK_W-1:0]  r_rd_data;
    logic [SLOT_W-1:0]  r_head_slot;
    logic               r_head_valid;
    logic [CHUNK_W-1:0] r_chunks;
    logic [SLOT_W-1:0]  r_carve_slot;
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [STATUS_W-1:0] r_out_status;

    logic [BASE_W-1:0]  w_base;
    logic [BASE_W-1:0]  w_top;
    logic               w_first;
    logic [SLOT_W-1:0]  w_prev_slot;
    logic               w_wr_en;
    logic [SLOT_W-1:0]  w_wr_addr;
    logic [LINK_W-1:0]  w_wr_data;
    logic               w_carve_last;

    assign w_base       = BASE_W'(r_chunks) * BASE_W'(BATCH_SLOTS);
    assign w_top        = w_base + BASE_W'(BATCH_SLOTS - 1);
    assign w_first      = (r_carve_slot == w_base[SLOT_W-1:0]);
    assign w_prev_slot  = r_carve_slot - SLOT_W'(1);
    assign w_carve_last = (r_carve_slot == w_top[SLOT_W-1:0]);

    // push from a release, or one ascending push per carve step
    always_comb begin
        w_wr_en   = i_cmd.push | i_cmd.carve_step;
        w_wr_addr = i_slot_index;
        w_wr_data = {r_head_valid, r_head_slot};
        if (i_cmd.carve_step) begin
            w_wr_addr = r_carve_slot;
            w_wr_data = w_first ? {1'b0, r_head_slot} : {1'b1, w_prev_slot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_link_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.pop_rd) begin
            r_rd_data <= r_link_mem[r_head_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_slot  <= '0;
            r_head_valid <= 1'b0;
            r_chunks     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_head_slot  <= i_slot_index;
                r_head_valid <= 1'b1;
            end
            if (i_cmd.pop_wb) begin
                r_head_slot  <= r_rd_data[SLOT_W-1:0];
                r_head_valid <= r_rd_data[SLOT_W];
            end
            if (i_cmd.carve_step && w_carve_last) begin
                // top slot of the chunk is handed out; the one below becomes head
                r_head_valid <= !w_first;
                if (!w_first) begin
                    r_head_slot <= w_prev_slot;
                end
                r_chunks <= r_chunks + CHUNK_W'(1);
            end
            if (i_cmd.post || i_cmd.pop_wb || (i_cmd.carve_step && w_carve_last)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.carve_start) begin
            r_carve_slot <= w_base[SLOT_W-1:0];
        end else if (i_cmd.carve_step) begin
            r_carve_slot <= r_carve_slot + SLOT_W'(1);
        end
        if (i_cmd.post) begin
            r_out_slot   <= '0;
            r_out_status <= i_cmd.post_status;
        end else if (i_cmd.pop_wb) begin
            r_out_slot   <= r_head_slot;
            r_out_status <= ST_ALLOCATED;
        end else if (i_cmd.carve_step && w_carve_last) begin
            r_out_slot   <= r_carve_slot;
            r_out_status <= ST_ALLOCATED;
        end
    end

    assign o_sts.head_valid = r_head_valid;
    assign o_sts.can_carve  = (r_chunks < CHUNK_W'(MAX_CHUNKS));
    assign o_sts.oversize   = (i_request_size > SIZE_W'(SLOT_BYTES));
    assign o_sts.carve_last = w_carve_last;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_granted_slot = r_out_slot;
    assign o_status       = r_out_status;

endmodule
`default_nettype wire

[hdl/fsfla_ctrl.sv]
// Controller: decodes each accepted beat and sequences pop, push and chunk carving.
`default_nettype none
module fsfla_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire                i_command,
    input  wire                i_slot_is_null,
    input  wire fsfla_pkg::t_dp_sts i_sts,
    output fsfla_pkg::t_dp_cmd o_cmd
);
    import fsfla_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_CARVE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_ALLOC) begin
                        if (i_sts.oversize) begin
                            o_cmd.post        = 1'b1;
                            o_cmd.post_status = ST_OVERSIZE;
                        end else if (i_sts.head_valid) begin
                            o_cmd.pop_rd = 1'b1;
                            n_state      = S_POP;
                        end else if (i_sts.can_carve) begin
                            o_cmd.carve_start = 1'b1;
                            n_state           = S_CARVE;
                        end else begin
                            o_cmd.post        = 1'b1;
                            o_cmd.post_status = ST_EXHAUSTED;
                        end
                    end else if (i_slot_is_null) begin
                        o_cmd.post        = 1'b1;
                        o_cmd.post_status = ST_NULL;
                    end else begin
                        o_cmd.push        = 1'b1;
                        o_cmd.post        = 1'b1;
                        o_cmd.post_status = ST_RELEASED;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_wb = 1'b1;
                n_state      = S_IDLE;
            end
            S_CARVE: begin
                o_cmd.carve_step = 1'b1;
                if (i_sts.carve_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[hdl/fixed_slot_free_list_allocator.sv]
// Top level of the fixed-slot free-list allocator.
// Hands out and takes back equal-sized slots kept as a LIFO free list whose next-slot
// links live in a 1024-entry single-port link memory. Release, oversize, exhausted and
// null beats are decided in the accepting cycle; an allocate from a non-empty free list
// does one link memory read, then the head update. An allocate that finds the list
// empty carves the next chunk: the accepting cycle, then one link write per slot.
// Results sit in an output register, so the next beat is taken while a result waits
// as long as the output side takes it in that cycle.
`default_nettype none
module fixed_slot_free_list_allocator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [15:0] request_size, [25:16] slot_index, rest zero
    input  wire  [1:0]  i_s_tuser,   // [0] command, [1] slot_is_null
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata,   // [9:0] granted_slot, rest zero
    output logic [2:0]  o_m_tuser    // [2:0] status
);
    import fsfla_pkg::*;

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [SLOT_W-1:0] w_granted_slot;

    fsfla_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_tvalid),
        .o_in_ready     (o_s_tready),
        .i_command      (i_s_tuser[0]),
        .i_slot_is_null (i_s_tuser[1]),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    fsfla_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_request_size (i_s_tdata[SIZE_W-1:0]),
        .i_slot_index   (i_s_tdata[SIZE_W+SLOT_W-1:SIZE_W]),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_granted_slot (w_granted_slot),
        .o_status       (o_m_tuser)
    );

    assign o_m_tdata = {{(16 - SLOT_W){1'b0}}, w_granted_slot};

endmodule
`default_nettype wire
